[src/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  typedef logic [31:0] word_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [7:0] PadByte = 8'h80;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

[src/sha_front.sv]
// ----------------------------------------------------------------------------
// sha_front
// Input queue: accepts items, drops idle ones, buffers the rest for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sha_pkg::item_t in_item,
  output logic               q_valid,
  input  wire logic          q_pop,
  output sha_pkg::item_t     q_item
);

  sha_pkg::item_t            mem_r [sha_pkg::QDepth];
  logic [sha_pkg::QAw-1:0]   wp_r, rp_r;
  logic [sha_pkg::QAw:0]     cnt_r;
  logic                      push;

  assign in_stall = (cnt_r == (sha_pkg::QAw+1)'(sha_pkg::QDepth));
  // items with neither flag set change nothing
  assign push     = in_valid && !in_stall &&
                    (in_item.byte_present || in_item.end_of_message);
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (sha_pkg::QAw+1)'(push) - (sha_pkg::QAw+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

endmodule
`default_nettype wire

[src/sha_back.sv]
// ----------------------------------------------------------------------------
// sha_back
// Block assembly, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire sha_pkg::item_t q_item,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_final_word
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]         st_r, st_nxt;
  sha_pkg::word_t     w_r [16];
  sha_pkg::word_t     h_r [8];
  sha_pkg::word_t     v_r [8];
  logic [5:0]         fill_r;
  logic [63:0]        total_r;
  logic [5:0]         rnd_r;
  logic               fin_r;     // compressing the final block
  logic               haspend_r; // end mark seen, pad still to write
  logic               padding_r; // message closed, length not yet written
  logic [2:0]         oidx_r;

  // padding byte stream
  logic               put;
  logic [7:0]         put_b;
  logic               len_blk;   // current pad byte completes a length block

  sha_pkg::word_t s0, s1, wn, big0, big1, ch, maj, t1;

  assign s0   = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1   = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn   = w_r[0] + s0 + w_r[9] + s1;
  assign big1 = sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^ sha_pkg::ror(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + big1 + ch + sha_pkg::RoundK[rnd_r] + w_r[0];
  assign big0 = sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^ sha_pkg::ror(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);

  assign q_pop = (st_r == StIdle) && q_valid;

  always_comb begin
    put   = 1'b0;
    put_b = 8'h00;
    len_blk = 1'b0;
    if (st_r == StIdle && q_valid && q_item.byte_present) begin
      put = 1'b1; put_b = q_item.data_byte;
    end else if (st_r == StPad) begin
      put = 1'b1;
      put_b = haspend_r ? sha_pkg::PadByte : 8'h00;
      // length goes in once 56 bytes are in a block and the 0x80 is placed
      len_blk = !haspend_r && (fill_r == 6'd56);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      StIdle: begin
        if (q_valid) begin
          if (q_item.byte_present && fill_r == 6'd63) st_nxt = StComp;
          else if (q_item.end_of_message) st_nxt = StPad;
        end
      end
      StPad: begin
        if (len_blk || fill_r == 6'd63) st_nxt = StComp;
      end
      StComp: if (rnd_r == 6'd63) st_nxt = StAdd;
      StAdd: begin
        if (fin_r) st_nxt = StOut;
        else if (padding_r) st_nxt = StPad;
        else st_nxt = StIdle;
      end
      StOut: if (!out_stall && oidx_r == 3'd7) st_nxt = StIdle;
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= StIdle;
      fill_r    <= '0;
      total_r   <= '0;
      rnd_r     <= '0;
      fin_r     <= 1'b0;
      haspend_r <= 1'b0;
      padding_r <= 1'b0;
      oidx_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitH[i];
    end else begin
      st_r <= st_nxt;
      if (q_pop) begin
        if (q_item.byte_present) total_r <= total_r + 64'd1;
        if (q_item.end_of_message) begin
          haspend_r <= 1'b1;
          padding_r <= 1'b1;
        end
      end
      if (st_r == StPad) haspend_r <= 1'b0;
      if (len_blk) begin
        fill_r    <= '0;
        fin_r     <= 1'b1;
        padding_r <= 1'b0;
      end else if (put) fill_r <= fill_r + 6'd1;
      if (st_r == StComp) rnd_r <= rnd_r + 6'd1;
      if (st_r == StAdd) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (st_r == StOut && !out_stall) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitH[i];
          total_r <= '0;
          fin_r   <= 1'b0;
        end
      end
    end
  end

  // block words and working variables
  always_ff @(posedge clk) begin
    if (put && !len_blk) begin
      w_r[fill_r[5:2]] <= (fill_r[1:0] == 2'd0) ? {put_b, 24'h0} :
        (w_r[fill_r[5:2]] | ({24'h0, put_b} << (6'd24 - {1'b0, fill_r[1:0], 3'b000})));
    end
    if (len_blk) begin
      w_r[14] <= total_r[60:29];
      w_r[15] <= {total_r[28:0], 3'b000};
    end
    if (st_nxt == StComp && st_r != StComp) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
    if (st_r == StComp) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + big0 + maj;
    end
  end

  assign out_valid       = (st_r == StOut);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_final_word  = (oidx_r == 3'd7);

endmodule
`default_nettype wire

[src/sha256_stream_hasher_core.sv]
// a byte is taken from the queue while idle; each full block then runs through
// compression (64 rounds on the shared round unit and a final add)
// end of message: padding, one or two compressions, then eight digest words
// one per cycle unless the receiver stalls; no new bytes are taken meanwhile
// reset: synchronous active low, hash words return to the initial values
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream with an input queue in front of the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_final_word
);

  sha_pkg::item_t in_item, q_item;
  logic           q_valid, q_pop;

  assign in_item = '{data_byte: in_data_byte, byte_present: in_byte_present,
                     end_of_message: in_end_of_message};

  sha_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  sha_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_final_word(out_final_word)
  );

endmodule
`default_nettype wire

[verif/sha256_checker.sv]
// ----------------------------------------------------------------------------
// sha256_checker
// Watches both channels, predicts the digest words of every closed message
// and compares each result transaction against the oldest expected word.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_digest_word,
  input  wire logic [2:0]  out_word_index,
  input  wire logic        out_final_word,
  output int               fail_count,
  output int               pending_words,
  output int               digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  digest_word_t    expected_words[$];
  sha_pkg::word_t  h_state[8];
  sha_pkg::word_t  blk[16];
  int unsigned     fill;
  logic [63:0]     msg_bytes;

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    sha_pkg::word_t w[64];
    sha_pkg::word_t v[8];
    sha_pkg::word_t t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = h_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h_state[i] += v[i];
  endtask

  task automatic add_byte(logic [7:0] b);
    int unsigned sh;
    sh = 24 - 8 * (fill % 4);
    if (fill % 4 == 0) blk[fill/4] = sha_pkg::word_t'(b) << sh;
    else blk[fill/4] |= sha_pkg::word_t'(b) << sh;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic take_item(logic [7:0] b, logic present, logic eom);
    logic [63:0] bits;
    digest_word_t d;
    if (present) begin
      msg_bytes++;
      add_byte(b);
    end
    if (eom) begin
      bits = msg_bytes << 3;
      add_byte(sha_pkg::PadByte);
      if (fill > 56) while (fill != 0) add_byte(8'h00);
      while (fill < 56) add_byte(8'h00);
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = h_state[i];
        d.idx  = 3'(i);
        d.last = (i == 7);
        expected_words.push_back(d);
      end
      for (int i = 0; i < 8; i++) h_state[i] = sha_pkg::InitH[i];
      fill = 0;
      msg_bytes = '0;
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) h_state[i] = sha_pkg::InitH[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
    msg_bytes = '0;
    fail_count = 0;
    pending_words = 0;
    digests_seen = 0;
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        take_item(in_data_byte, in_byte_present, in_end_of_message);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h idx %0d", out_digest_word, out_word_index);
        end else begin
          want = expected_words.pop_front();
          if (want.word !== out_digest_word || want.idx !== out_word_index ||
              want.last !== out_final_word) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h/%0d/%b got %h/%0d/%b", want.word,
                       want.idx, want.last, out_digest_word, out_word_index,
                       out_final_word);
          end
          if (want.last) digests_seen++;
        end
      end
      pending_words = expected_words.size();
    end
  end
endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the SHA-256 stream hasher: directed and random messages under
// several idling phases, verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_final_word;
  int          fail_count;
  int          pending_words;
  int          digests_seen;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          idle_cycles;
  int          items_sent;

  localparam int WatchdogLimit = 20000;

  sha256_stream_hasher_core u_top (.*);

  sha256_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side stalls at random
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge; valid stays high until the next call, which may drop it for idle gaps
  task automatic send_item(logic [7:0] b, logic present, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, logic end_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
    if (!end_with_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int sizes[8] = '{55, 56, 63, 64, 0, 1, 119, 120};
    int len;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_present = 1'b0;
    in_end_of_message = 1'b0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty message, extremes of the byte, idle items
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // random messages, some at the padding boundaries, four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 82 : (ph == 3) ? 23 : 0;
      recv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 23 : 0;
      for (int m = 0; m < 4; m++) begin
        case ($urandom_range(3))
          0: len = sizes[$urandom_range(7)];
          default: len = $urandom_range(12);
        endcase
        send_message(len, $urandom_range(1));
        if ($urandom_range(3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      end
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d items, %0d digests checked across four idling phases",
             items_sent, digests_seen);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
